/* design/analog_key_actuation_detector_top_macros.svh */
// ---------------------------------------------------------------------------
// analog_key_actuation_detector_top_macros.svh
// Assertion macros shared by the checker of the key actuation detector.
// ---------------------------------------------------------------------------
`ifndef ANALOG_KEY_ACTUATION_DETECTOR_TOP_MACROS_SVH
`define ANALOG_KEY_ACTUATION_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define AKAD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("akad check failed: same-cycle implication");

// Next-cycle implication, checked outside reset
`define AKAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("akad check failed: next-cycle implication");

`endif

/* design/akad_pkg.sv */
// ---------------------------------------------------------------------------
// akad_pkg
// Shared types and constants of the analog key actuation detector.
// ---------------------------------------------------------------------------
package akad_pkg;

  // Number of tracked keys and index widths
  localparam int MAX_KEYS = 256;
  localparam int KEY_W    = $clog2(MAX_KEYS);
  // row (5b) * group width (6b) + col (5b) fits 11 bits
  localparam int IDX_W    = 11;

  // Last sample after reset
  localparam logic signed [15:0] LAST_RESET = 16'sd10000;
  // Group width used when the register holds zero
  localparam logic [5:0] DEFAULT_COLS = 6'd8;

  // Configuration register indexes
  localparam logic [2:0] CFG_GROUP_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SENSITIVITY  = 3'd1;
  localparam logic [2:0] CFG_FWD_ENABLE   = 3'd2;
  localparam logic [2:0] CFG_ACT_POINT    = 3'd3;
  localparam logic [2:0] CFG_KEY_COUNT    = 3'd4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PASSED   = 2'd0,
    ST_CONSUMED = 2'd1,
    ST_DROPPED  = 2'd2
  } status_t;

  // Per-key state write
  typedef struct packed {
    logic                    en;
    logic [KEY_W-1:0]        idx;
    logic signed [15:0]      value;
    logic                    down;
  } key_wr_t;

endpackage

/* design/analog_key_actuation_detector_top.sv */
// ---------------------------------------------------------------------------
// analog_key_actuation_detector_top
// Analog key press and release detection with hysteresis.
// ---------------------------------------------------------------------------
// One item is accepted per clock unless the output stalls. It is registered
// in stage 1 with the read of the per-key sample memory (registered read
// port), then in the result register. Back-to-back samples of the same key
// are handled by a write bypass. A sensor sample (in_tuser high) is mapped to
// key row * group_width + col; indexes at or above key_count are dropped.
// A falling value tests for a press at actuation_point - sensitivity/2, any
// other value for a release at actuation_point + sensitivity/2; a crossing
// that changes the key state is reported when forwarding is enabled.
// Configuration must be written while the block is idle.
// ---------------------------------------------------------------------------
module analog_key_actuation_detector_top (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // key_row[4:0], key_col[9:5], sample_value[25:10]
  input  logic        in_tuser,   // is_hall_event[0]
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // changed[0], pressed[1], out_row[6:2], out_col[11:7]
  output logic [1:0]  out_tuser   // status[1:0]
);

  // Configuration registers
  logic [5:0]          gw_r;
  logic [11:0]         sens_r;
  logic                fwd_r;
  logic signed [15:0]  ap_r;
  logic [8:0]          kc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r   <= '0;
      sens_r <= '0;
      fwd_r  <= 1'b0;
      ap_r   <= '0;
      kc_r   <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        akad_pkg::CFG_GROUP_WIDTH: gw_r   <= cfg_wdata[5:0];
        akad_pkg::CFG_SENSITIVITY: sens_r <= cfg_wdata[11:0];
        akad_pkg::CFG_FWD_ENABLE:  fwd_r  <= cfg_wdata[0];
        akad_pkg::CFG_ACT_POINT:   ap_r   <= cfg_wdata;
        akad_pkg::CFG_KEY_COUNT:   kc_r   <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic [4:0]         in_row;
  logic [4:0]         in_col;
  logic signed [15:0] in_val;

  assign in_row = in_tdata[4:0];
  assign in_col = in_tdata[9:5];
  assign in_val = in_tdata[25:10];

  // Key index and range check
  logic [5:0]                   cols;
  logic [akad_pkg::IDX_W-1:0]   idx_full;
  logic [akad_pkg::IDX_W-1:0]   kc_ext;
  logic [akad_pkg::IDX_W-1:0]   max_ext;
  logic [akad_pkg::IDX_W-1:0]   limit;
  logic                         in_range;

  assign cols     = (gw_r == 6'd0) ? akad_pkg::DEFAULT_COLS : gw_r;
  assign idx_full = akad_pkg::IDX_W'(in_row) * akad_pkg::IDX_W'(cols)
                  + akad_pkg::IDX_W'(in_col);
  assign kc_ext   = akad_pkg::IDX_W'(kc_r);
  assign max_ext  = akad_pkg::IDX_W'(akad_pkg::MAX_KEYS);
  assign limit    = (kc_ext < max_ext) ? kc_ext : max_ext;
  assign in_range = idx_full < limit;

  // Handshake
  logic s1_v_r;
  logic s1_adv;
  logic in_xfer;
  logic out_v_r;

  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  // Stage 1 item register
  logic                         s1_hall_r;
  logic                         s1_inr_r;
  logic [akad_pkg::KEY_W-1:0]   s1_idx_r;
  logic [4:0]                   s1_row_r;
  logic [4:0]                   s1_col_r;
  logic signed [15:0]           s1_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_hall_r <= in_tuser;
      s1_inr_r  <= in_range;
      s1_idx_r  <= idx_full[akad_pkg::KEY_W-1:0];
      s1_row_r  <= in_row;
      s1_col_r  <= in_col;
      s1_val_r  <= in_val;
    end
  end

  // Per-key state
  akad_pkg::key_wr_t    wr;
  logic signed [15:0]   last;
  logic                 down;

  akad_key_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_idx  (idx_full[akad_pkg::KEY_W-1:0]),
    .wr      (wr),
    .rd_last (last),
    .rd_down (down)
  );

  // Threshold test with hysteresis
  logic signed [17:0] ap_x;
  logic signed [17:0] half_x;
  logic signed [17:0] val_x;
  logic signed [17:0] last_x;
  logic signed [17:0] trig;
  logic               falling;
  logic               crossed;
  logic               consume;
  logic               chg;
  akad_pkg::status_t  status;

  assign ap_x    = 18'(ap_r);
  assign half_x  = $signed({7'd0, sens_r[11:1]});
  assign val_x   = 18'(s1_val_r);
  assign last_x  = 18'(last);
  assign falling = s1_val_r < last;
  assign trig    = falling ? (ap_x - half_x) : (ap_x + half_x);
  assign crossed = falling ? ((val_x < trig) && (last_x >= trig))
                           : ((val_x > trig) && (last_x <= trig));
  assign consume = s1_hall_r && s1_inr_r;
  assign chg     = consume && fwd_r && crossed && (down != falling);

  always_comb begin
    priority if (!s1_hall_r) begin
      status = akad_pkg::ST_PASSED;
    end else if (!s1_inr_r) begin
      status = akad_pkg::ST_DROPPED;
    end else begin
      status = akad_pkg::ST_CONSUMED;
    end
  end

  // State update as the item leaves stage 1
  assign wr.en    = s1_v_r && s1_adv && consume;
  assign wr.idx   = s1_idx_r;
  assign wr.value = s1_val_r;
  assign wr.down  = chg ? falling : down;

  // Result register
  akad_pkg::status_t out_status_r;
  logic              out_chg_r;
  logic              out_prs_r;
  logic [4:0]        out_row_r;
  logic [4:0]        out_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v_r) begin
      out_status_r <= status;
      out_chg_r    <= chg;
      out_prs_r    <= chg && falling;
      out_row_r    <= s1_row_r;
      out_col_r    <= s1_col_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_col_r, out_row_r, out_prs_r, out_chg_r};
  assign out_tuser  = out_status_r;

endmodule

/* design/akad_key_store.sv */
// ---------------------------------------------------------------------------
// akad_key_store
// Per-key last sample and pressed bit memories, registered read with bypass
// of a write to the same key in the read cycle. One valid bit per key,
// cleared by reset, makes unwritten keys read as the reset state.
// ---------------------------------------------------------------------------
module akad_key_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             rd_en,
  input  logic [akad_pkg::KEY_W-1:0]       rd_idx,
  input  akad_pkg::key_wr_t                wr,
  output logic signed [15:0]               rd_last,
  output logic                             rd_down
);

  logic signed [15:0]             last_mem_r [akad_pkg::MAX_KEYS];
  logic                           down_mem_r [akad_pkg::MAX_KEYS];
  logic [akad_pkg::MAX_KEYS-1:0]  valid_r;

  logic signed [15:0] mem_q_r;
  logic               vld_q_r;
  logic               down_q_r;
  logic               byp_r;
  logic signed [15:0] byp_val_r;
  logic               byp_down_r;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      last_mem_r[wr.idx] <= wr.value;
      down_mem_r[wr.idx] <= wr.down;
    end
    if (rd_en) begin
      mem_q_r    <= last_mem_r[rd_idx];
      down_q_r   <= down_mem_r[rd_idx];
      byp_val_r  <= wr.value;
      byp_down_r <= wr.down;
    end
  end

  // Valid bits and bypass flag, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      vld_q_r  <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        vld_q_r  <= valid_r[rd_idx];
        byp_r    <= wr.en && (wr.idx == rd_idx);
      end
    end
  end

  // Bypass wins, unwritten entries read as the reset state
  assign rd_last = byp_r   ? byp_val_r :
                   vld_q_r ? mem_q_r   : akad_pkg::LAST_RESET;
  assign rd_down = byp_r ? byp_down_r : (vld_q_r && down_q_r);

endmodule

/* design/akad_checker.sv */
// ---------------------------------------------------------------------------
// akad_checker
// Port-level checks of the key actuation detector, bound to the top level.
// ---------------------------------------------------------------------------
`include "analog_key_actuation_detector_top_macros.svh"

module akad_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // Stalled result holds
  `AKAD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Status is one of the three defined codes
  `AKAD_ASSERT_NOW(a_status_code, out_tvalid, (out_tuser == akad_pkg::ST_PASSED) || (out_tuser == akad_pkg::ST_CONSUMED) || (out_tuser == akad_pkg::ST_DROPPED))

  // Only a consumed sample reports a change
  `AKAD_ASSERT_NOW(a_chg_consumed, out_tvalid && out_tdata[0], out_tuser == akad_pkg::ST_CONSUMED)

  // A press is always reported as a change
  `AKAD_ASSERT_NOW(a_press_chg, out_tvalid && out_tdata[1], out_tdata[0])

endmodule

bind analog_key_actuation_detector_top akad_checker u_akad_checker (.*);

/* dv/tb_analog_key_actuation_detector_top.sv */
// ---------------------------------------------------------------------------
// tb_analog_key_actuation_detector_top
// Self-checking bench for the analog key actuation detector. A queue-fed
// driver sends key samples in random bursts. The receiver stalls on a pattern
// that changes over time. Each accepted sample runs through a local
// hysteresis tracker, and every result transfer is checked against the
// oldest prediction. The run covers a directed set and then random phases
// under several register settings, extremes included.
// ---------------------------------------------------------------------------
module tb_analog_key_actuation_detector_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic               hall;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [15:0] value;
  } key_sample_t;

  typedef struct {
    akad_pkg::status_t status;
    logic              changed;
    logic              pressed;
    logic [4:0]        row;
    logic [4:0]        col;
  } key_report_t;

  // DUT signals; the inputs are all known from time zero
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_idx    = akad_pkg::CFG_GROUP_WIDTH;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  analog_key_actuation_detector_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // key_row[4:0], key_col[9:5], sample_value[25:10]
    .in_tuser   (in_tuser),   // is_hall_event[0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // changed[0], pressed[1], out_row[6:2], out_col[11:7]
    .out_tuser  (out_tuser)   // status[1:0]
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Mirror of the register file
  int gw_mirror;
  int sens_mirror;
  int fwd_mirror;
  int act_mirror;
  int kcount_mirror;

  // Mirror of the per-key state
  logic signed [15:0] key_last [akad_pkg::MAX_KEYS];
  logic               key_is_down [akad_pkg::MAX_KEYS];

  key_sample_t pending_samples[$];
  key_report_t expected_reports[$];

  logic in_fire = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;
  bit [7:0] stall_tick = '0;

  int failures = 0;
  int cycle_count = 0;
  int samples_accepted = 0;
  int results_checked = 0;
  int press_reports = 0;
  int release_reports = 0;
  int dropped_reports = 0;
  int passed_reports = 0;
  int settings_used = 0;
  int directed_items = 0;
  int random_items = 0;

  // Hysteresis tracker: works out the result of one accepted item
  function automatic key_report_t detect_key_transition(input key_sample_t s);
    key_report_t r;
    int cols, idx, limit, half, trig, last, v;
    bit falling, crossed;
    r.status  = akad_pkg::ST_PASSED;
    r.changed = 1'b0;
    r.pressed = 1'b0;
    r.row     = s.row;
    r.col     = s.col;
    if (s.hall) begin
      cols  = (gw_mirror == 0) ? int'(akad_pkg::DEFAULT_COLS) : gw_mirror;
      idx   = int'(s.row) * cols + int'(s.col);
      limit = (kcount_mirror < akad_pkg::MAX_KEYS) ? kcount_mirror : akad_pkg::MAX_KEYS;
      if (idx >= limit) begin
        r.status = akad_pkg::ST_DROPPED;
      end else begin
        last    = int'(key_last[idx]);
        v       = int'(s.value);
        half    = sens_mirror / 2;
        falling = v < last;
        trig    = falling ? act_mirror - half : act_mirror + half;
        crossed = falling ? (v < trig && last >= trig) : (v > trig && last <= trig);
        r.status = akad_pkg::ST_CONSUMED;
        if (fwd_mirror != 0 && crossed && key_is_down[idx] != falling) begin
          key_is_down[idx] = falling;
          r.changed = 1'b1;
          r.pressed = falling;
        end
        key_last[idx] = s.value;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  // Result checking, input prediction and the run limit
  always @(posedge clk) begin
    key_report_t want;
    key_sample_t s;
    cycle_count++;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        $error("result transfer with nothing expected: status %0d data %0h",
               out_tuser, out_tdata);
        failures++;
      end else begin
        want = expected_reports.pop_front();
        check_field("status", 16'(want.status), 16'(out_tuser));
        check_field("changed", 16'(want.changed), 16'(out_tdata[0]));
        check_field("pressed", 16'(want.pressed), 16'(out_tdata[1]));
        check_field("out_row", 16'(want.row), 16'(out_tdata[6:2]));
        check_field("out_col", 16'(want.col), 16'(out_tdata[11:7]));
        results_checked++;
        if (want.changed && want.pressed) press_reports++;
        if (want.changed && !want.pressed) release_reports++;
        if (want.status == akad_pkg::ST_DROPPED) dropped_reports++;
        if (want.status == akad_pkg::ST_PASSED) passed_reports++;
      end
    end
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      s.hall  = in_tuser;
      s.row   = in_tdata[4:0];
      s.col   = in_tdata[9:5];
      s.value = in_tdata[25:10];
      expected_reports.push_back(detect_key_transition(s));
      samples_accepted++;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sender: bursts of random length with random gaps
  always @(negedge clk) begin
    key_sample_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_fire || !in_tvalid) begin
      if (gap_left > 0 || pending_samples.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        s = pending_samples.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= s.hall;
        in_tdata  <= {6'd0, s.value, s.col, s.row};
        if (burst_left <= 1) begin
          burst_left = int'($urandom_range(1, 24));
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: one of four stall modes, picked anew at random
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = int'($urandom_range(0, 3));
        mode_left  = int'($urandom_range(16, 64));
      end else begin
        mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (stall_tick[1:0] == 2'd0);
        default: out_tready <= stall_tick[3];
      endcase
    end
  end

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int pick_range(input int lo, input int hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic void queue_sample(input logic hall, input logic [4:0] row,
                                       input logic [4:0] col,
                                       input logic signed [15:0] value);
    key_sample_t s;
    s.hall  = hall;
    s.row   = row;
    s.col   = col;
    s.value = value;
    pending_samples.push_back(s);
  endfunction

  // One key stroke: down past the press point and back up past the release
  // point; some strokes stay inside the hysteresis band
  function automatic int queue_stroke(input logic [4:0] row, input logic [4:0] col);
    int half, lo, hi, steps, n, v;
    half  = sens_mirror / 2;
    steps = int'($urandom_range(1, 5));
    n     = 0;
    if ($urandom_range(0, 4) == 0) begin
      lo = act_mirror - int'($urandom_range(0, half));
      hi = act_mirror + int'($urandom_range(0, half));
    end else begin
      lo = act_mirror - half - int'($urandom_range(1, 300));
      hi = act_mirror + half + int'($urandom_range(1, 300));
    end
    for (int i = 0; i <= 2 * steps; i++) begin
      if (i <= steps) v = hi - (hi - lo) * i / steps;
      else            v = lo + (hi - lo) * (i - steps) / steps;
      v += int'($urandom_range(0, 20)) - 10;
      queue_sample(1'b1, row, col, clamp16(v));
      n++;
      // repeated reading
      if ($urandom_range(0, 5) == 0) begin
        queue_sample(1'b1, row, col, clamp16(v));
        n++;
      end
    end
    return n;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[15:0];
    case (idx)
      akad_pkg::CFG_GROUP_WIDTH: gw_mirror     = value & 'h3f;
      akad_pkg::CFG_SENSITIVITY: sens_mirror   = value & 'hfff;
      akad_pkg::CFG_FWD_ENABLE:  fwd_mirror    = value & 1;
      akad_pkg::CFG_ACT_POINT:   act_mirror    = int'($signed(value[15:0]));
      akad_pkg::CFG_KEY_COUNT:   kcount_mirror = value & 'h1ff;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_config(input int gw, input int sens, input int fwd,
                              input int act, input int kcount);
    write_reg(akad_pkg::CFG_GROUP_WIDTH, gw);
    write_reg(akad_pkg::CFG_SENSITIVITY, sens);
    write_reg(akad_pkg::CFG_FWD_ENABLE, fwd);
    write_reg(akad_pkg::CFG_ACT_POINT, act);
    write_reg(akad_pkg::CFG_KEY_COUNT, kcount);
    settings_used++;
  endtask

  // Block is idle once every queued item is sent and every result is back
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_tvalid || expected_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    logic [4:0] ws_row [4];
    logic [4:0] ws_col [4];
    int cols, limit, span, idx, k, roll, phase, target, phase_items;
    bit have_keys;

    gw_mirror     = 0;
    sens_mirror   = 0;
    fwd_mirror    = 0;
    act_mirror    = 0;
    kcount_mirror = akad_pkg::MAX_KEYS;
    for (int i = 0; i < akad_pkg::MAX_KEYS; i++) begin
      key_last[i]    = akad_pkg::LAST_RESET;
      key_is_down[i] = 1'b0;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: forwarding off, eight columns per row
    queue_sample(1'b0, 5'd31, 5'd31, 16'sh7fff);
    queue_sample(1'b0, 5'd0, 5'd0, 16'sh8000);
    queue_sample(1'b1, 5'd31, 5'd31, 16'sd0);       // index beyond key count
    queue_sample(1'b1, 5'd0, 5'd0, 16'sh8000);      // crossing, forwarding off
    queue_sample(1'b1, 5'd31, 5'd7, 16'sh7fff);     // highest tracked key
    queue_sample(1'b1, 5'd0, 5'd0, 16'sh8000);      // same value again
    directed_items += 6;
    wait_idle();

    // Forwarding on, wide groups, narrow hysteresis band
    write_config(32, 100, 1, 0, akad_pkg::MAX_KEYS);
    queue_sample(1'b1, 5'd1, 5'd2, -16'sd500);      // press
    queue_sample(1'b1, 5'd1, 5'd2, -16'sd500);      // equal value
    queue_sample(1'b1, 5'd1, 5'd2, 16'sd500);       // release
    queue_sample(1'b1, 5'd1, 5'd2, 16'sd20);        // falls but stays in band
    queue_sample(1'b1, 5'd1, 5'd2, -16'sd100);      // press
    queue_sample(1'b1, 5'd1, 5'd2, 16'sd0);         // rises inside band
    queue_sample(1'b1, 5'd1, 5'd2, -16'sd100);      // press crossing while down
    queue_sample(1'b1, 5'd1, 5'd2, 16'sh7fff);      // release
    queue_sample(1'b1, 5'd1, 5'd2, 16'sh8000);      // press
    queue_sample(1'b1, 5'd1, 5'd2, 16'sh7fff);      // release
    queue_sample(1'b1, 5'd31, 5'd31, 16'sd0);       // far out of range
    queue_sample(1'b1, 5'd7, 5'd31, 16'sd0);        // last in range
    queue_sample(1'b1, 5'd8, 5'd0, 16'sd0);         // first out of range
    directed_items += 13;
    wait_idle();

    // Random phases, each under its own register setting
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: write_config(0, 0, 1, 0, akad_pkg::MAX_KEYS);
        1: write_config(32, 4095, 1, 32767, akad_pkg::MAX_KEYS);
        2: write_config(1, 4095, 1, -32768, 1);
        3: write_config(pick_range(0, 32), pick_range(0, 4095), 1,
                        pick_range(0, 65535) - 32768, 0);
        default:
          write_config(pick_range(0, 32), pick_range(0, 4095),
                       int'($urandom_range(0, 4) != 0),
                       ($urandom_range(0, 2) == 0) ? pick_range(0, 65535) - 32768
                                                   : int'($urandom_range(0, 8000)) - 4000,
                       ($urandom_range(0, 3) == 0)
                         ? pick_range(0, akad_pkg::MAX_KEYS)
                         : int'($urandom_range(64, akad_pkg::MAX_KEYS)));
      endcase

      // Small working set of tracked keys for this setting
      cols      = (gw_mirror == 0) ? int'(akad_pkg::DEFAULT_COLS) : gw_mirror;
      limit     = (kcount_mirror < akad_pkg::MAX_KEYS) ? kcount_mirror : akad_pkg::MAX_KEYS;
      span      = (limit < 32 * cols) ? limit : 32 * cols;
      have_keys = span > 0;
      for (int i = 0; i < 4; i++) begin
        idx       = have_keys ? int'($urandom_range(0, span - 1)) : 0;
        ws_row[i] = 5'(idx / cols);
        ws_col[i] = 5'(idx % cols);
      end

      target      = (phase == 3) ? 30 : int'($urandom_range(60, 120));
      phase_items = 0;
      while (phase_items < target) begin
        roll = int'($urandom_range(0, 99));
        if (roll < 70 && have_keys) begin
          k = int'($urandom_range(0, 3));
          phase_items += queue_stroke(ws_row[k], ws_col[k]);
        end else if (roll < 85) begin
          queue_sample(1'b0, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                       16'($urandom_range(0, 65535)));
          phase_items++;
        end else begin
          queue_sample(1'b1, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                       16'($urandom_range(0, 65535)));
          phase_items++;
        end
      end
      random_items += phase_items;
      wait_idle();
      phase++;
    end

    $display("Covered %0d input transfers (%0d directed) under %0d register settings",
             samples_accepted, directed_items, settings_used + 1);
    $display("Checked %0d results: %0d presses, %0d releases, %0d dropped, %0d passed on",
             results_checked, press_reports, release_reports, dropped_reports,
             passed_reports);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/akad_pkg.sv
design/akad_key_store.sv
design/analog_key_actuation_detector_top.sv
design/akad_checker.sv
dv/tb_analog_key_actuation_detector_top.sv
